// File: hw/rtl/assert_macros.svh
// Assertion macros for RTL that checks its own logic.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define ASSERT_PROP(label, clk, rst, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("%m: property failed");
`define ASSERT_NEVER(label, clk, rst, expr) \
  label: assert property (@(posedge clk) disable iff (rst) !(expr)) \
    else $error("%m: forbidden condition seen");
`else
`define ASSERT_PROP(label, clk, rst, prop)
`define ASSERT_NEVER(label, clk, rst, expr)
`endif
`endif

// File: hw/rtl/tcb_pkg.sv
package tcb_pkg;

  localparam int MAX_ROWS = 32;
  localparam int MAX_COLS = 128;
  localparam int ROW_W    = $clog2(MAX_ROWS);
  localparam int COL_W    = $clog2(MAX_COLS);
  localparam int ADDR_W   = ROW_W + COL_W;
  localparam int NROW_W   = 6;
  localparam int NCOL_W   = 8;

  localparam logic [7:0] CH_BS    = 8'd8;
  localparam logic [7:0] CH_LF    = 8'd10;
  localparam logic [7:0] CH_FF    = 8'd12;
  localparam logic [7:0] CH_CR    = 8'd13;
  localparam logic [7:0] CH_SPACE = 8'd32;

  localparam logic [1:0] CMD_PUT   = 2'd0;
  localparam logic [1:0] CMD_READ  = 2'd1;
  localparam logic [1:0] CMD_FRESH = 2'd2;

  localparam logic REG_NUM_ROWS = 1'b0;
  localparam logic REG_NUM_COLS = 1'b1;

  localparam logic [NROW_W-1:0] NUM_ROWS_RESET = 6'd24;
  localparam logic [NCOL_W-1:0] NUM_COLS_RESET = 8'd80;

  localparam logic [1:0] CUR_HOLD = 2'd0;
  localparam logic [1:0] CUR_FIX  = 2'd1;
  localparam logic [1:0] CUR_HOME = 2'd2;
  localparam logic [1:0] CUR_ADV  = 2'd3;

  localparam logic [1:0] WR_NONE  = 2'd0;
  localparam logic [1:0] WR_SWEEP = 2'd1;
  localparam logic [1:0] WR_FILL  = 2'd2;
  localparam logic [1:0] WR_PUT   = 2'd3;

  localparam logic [1:0] RD_NONE   = 2'd0;
  localparam logic [1:0] RD_ITEM   = 2'd1;
  localparam logic [1:0] RD_SCROLL = 2'd2;

  typedef struct packed {
    logic       load_item;
    logic [1:0] cur_op;
    logic       mask_clear;
    logic       scroll_start;
    logic [1:0] wr_op;
    logic [1:0] rd_op;
    logic       load_out;
  } tcb_cmd_t;

  typedef struct packed {
    logic [1:0] item_cmd;
    logic       ch_cr;
    logic       ch_lf;
    logic       ch_ff;
    logic       ch_bs;
    logic       need_scroll;
    logic       rows_one;
    logic       scan_col_last;
    logic       scan_row_last;
    logic       sweep_last;
    logic       copy_pend;
    logic       out_free;
  } tcb_status_t;

  function automatic logic [MAX_ROWS-1:0] all_rows_mask(input logic [NROW_W-1:0] rows);
    logic [MAX_ROWS:0] m;
    m = ({{MAX_ROWS{1'b0}}, 1'b1} << rows) - {{MAX_ROWS{1'b0}}, 1'b1};
    return m[MAX_ROWS-1:0];
  endfunction

endpackage

// File: hw/rtl/tcb_if.sv
interface tcb_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] command;
  logic [7:0] char_code;
  logic [4:0] read_row;
  logic [6:0] read_col;

  modport source (output valid, command, char_code, read_row, read_col, input ready);
  modport sink (input valid, command, char_code, read_row, read_col, output ready);
endinterface

interface tcb_out_if;
  logic        valid;
  logic        ready;
  logic [4:0]  pos_row;
  logic [7:0]  pos_col;
  logic [7:0]  read_char;
  logic [31:0] stale_rows;
  logic        scrolled;

  modport source (output valid, pos_row, pos_col, read_char, stale_rows, scrolled,
                  input ready);
  modport sink (input valid, pos_row, pos_col, read_char, stale_rows, scrolled,
                output ready);
endinterface

// File: hw/rtl/tcb_datapath.sv
module tcb_datapath
  import tcb_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_wr_en,
  input  logic                cfg_index,
  input  logic [NCOL_W-1:0]   cfg_data,
  input  logic [1:0]          command,
  input  logic [7:0]          char_code,
  input  logic [ROW_W-1:0]    read_row,
  input  logic [COL_W-1:0]    read_col,
  input  logic                rsp_ready,
  output logic                rsp_valid,
  output logic [ROW_W-1:0]    pos_row,
  output logic [NCOL_W-1:0]   pos_col,
  output logic [7:0]          read_char,
  output logic [MAX_ROWS-1:0] stale_rows,
  output logic                scrolled,
  input  tcb_cmd_t            cmd,
  output tcb_status_t         st
);

  logic [7:0]          mem [MAX_ROWS*MAX_COLS];

  logic [NROW_W-1:0]   num_rows;
  logic [NCOL_W-1:0]   num_cols;
  logic [1:0]          item_cmd;
  logic [7:0]          item_ch;
  logic [ROW_W-1:0]    item_rr;
  logic [COL_W-1:0]    item_rc;
  logic [ROW_W-1:0]    cur_row;
  logic [NCOL_W-1:0]   cur_col;
  logic [MAX_ROWS-1:0] row_changed;
  logic [MAX_ROWS-1:0] row_changed_next;
  logic                scroll_flag;
  logic [ROW_W-1:0]    sc_row;
  logic [COL_W-1:0]    sc_col;
  logic [ADDR_W-1:0]   sweep_addr;
  logic                copy_pend;
  logic [ADDR_W-1:0]   copy_addr;
  logic [7:0]          rd_data;

  logic [NROW_W-1:0]   rows_eff;
  logic [NROW_W-1:0]   rows_m1;
  logic [NCOL_W-1:0]   cols_eff;
  logic [NROW_W-1:0]   pre_row;
  logic [NROW_W-1:0]   row_a;
  logic [NCOL_W-1:0]   pre_col;
  logic [NCOL_W-1:0]   col_a;
  logic                wrap;
  logic                need_scroll;
  logic [ROW_W-1:0]    fix_row;
  logic                mem_we;
  logic [ADDR_W-1:0]   mem_waddr;
  logic [7:0]          mem_wdata;
  logic                rd_en;
  logic [ADDR_W-1:0]   rd_addr;
  logic                col_last;

  always_comb begin
    if (num_rows == '0) begin
      rows_eff = NROW_W'(1);
    end else if (num_rows > NROW_W'(MAX_ROWS)) begin
      rows_eff = NROW_W'(MAX_ROWS);
    end else begin
      rows_eff = num_rows;
    end
    if (num_cols == '0) begin
      cols_eff = NCOL_W'(1);
    end else if (num_cols > NCOL_W'(MAX_COLS)) begin
      cols_eff = NCOL_W'(MAX_COLS);
    end else begin
      cols_eff = num_cols;
    end
  end

  assign rows_m1 = rows_eff - NROW_W'(1);

  // The cursor move of a line feed or backspace, followed by the wrap and scroll check.
  always_comb begin
    pre_row = {1'b0, cur_row};
    pre_col = cur_col;
    if (item_ch == CH_LF) begin
      pre_row = {1'b0, cur_row} + NROW_W'(1);
      pre_col = '0;
    end else if (item_ch == CH_BS) begin
      if (cur_col == '0) begin
        pre_col = cols_eff - NCOL_W'(1);
        pre_row = (cur_row == '0) ? '0 : {1'b0, cur_row} - NROW_W'(1);
      end else begin
        pre_col = cur_col - NCOL_W'(1);
      end
    end
    wrap        = (pre_col >= cols_eff);
    row_a       = pre_row + {{(NROW_W-1){1'b0}}, wrap};
    col_a       = wrap ? '0 : pre_col;
    need_scroll = (row_a >= rows_eff);
    fix_row     = need_scroll ? rows_m1[ROW_W-1:0] : row_a[ROW_W-1:0];
  end

  assign col_last = ({1'b0, sc_col} == (cols_eff - NCOL_W'(1)));

  always_comb begin
    row_changed_next = row_changed;
    if (cmd.mask_clear) begin
      row_changed_next = '0;
    end else begin
      if (cmd.scroll_start) begin
        row_changed_next = row_changed_next | all_rows_mask(rows_eff);
      end
      if (cmd.cur_op == CUR_ADV) begin
        row_changed_next = row_changed_next | (MAX_ROWS'(1) << cur_row);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      num_rows <= NUM_ROWS_RESET;
      num_cols <= NUM_COLS_RESET;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        REG_NUM_ROWS: num_rows <= cfg_data[NROW_W-1:0];
        REG_NUM_COLS: num_cols <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_item) begin
      item_cmd <= command;
      item_ch  <= char_code;
      item_rr  <= read_row;
      item_rc  <= read_col;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_row     <= '0;
      cur_col     <= '0;
      row_changed <= '0;
      scroll_flag <= 1'b0;
    end else begin
      row_changed <= row_changed_next;
      case (cmd.cur_op)
        CUR_FIX: begin
          cur_row <= fix_row;
          cur_col <= col_a;
        end
        CUR_HOME: begin
          cur_row <= '0;
          cur_col <= '0;
        end
        CUR_ADV: cur_col <= cur_col + NCOL_W'(1);
        default: ;
      endcase
      if (cmd.load_item) begin
        scroll_flag <= 1'b0;
      end else if (cmd.scroll_start) begin
        scroll_flag <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sweep_addr <= '0;
      copy_pend  <= 1'b0;
    end else begin
      copy_pend <= (cmd.rd_op == RD_SCROLL);
      if (cmd.wr_op == WR_SWEEP) begin
        sweep_addr <= sweep_addr + ADDR_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    copy_addr <= {sc_row, sc_col};
    if (cmd.scroll_start) begin
      sc_row <= '0;
      sc_col <= '0;
    end else if (cmd.rd_op == RD_SCROLL) begin
      if (col_last) begin
        sc_col <= '0;
        sc_row <= sc_row + ROW_W'(1);
      end else begin
        sc_col <= sc_col + COL_W'(1);
      end
    end else if (cmd.wr_op == WR_FILL) begin
      sc_col <= col_last ? '0 : sc_col + COL_W'(1);
    end
  end

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = sweep_addr;
    mem_wdata = CH_SPACE;
    if (copy_pend) begin
      mem_we    = 1'b1;
      mem_waddr = copy_addr;
      mem_wdata = rd_data;
    end else begin
      case (cmd.wr_op)
        WR_SWEEP: mem_we = 1'b1;
        WR_FILL: begin
          mem_we    = 1'b1;
          mem_waddr = {rows_m1[ROW_W-1:0], sc_col};
        end
        WR_PUT: begin
          mem_we    = 1'b1;
          mem_waddr = {cur_row, cur_col[COL_W-1:0]};
          mem_wdata = item_ch;
        end
        default: ;
      endcase
    end
  end

  always_comb begin
    rd_en   = 1'b0;
    rd_addr = {item_rr, item_rc};
    case (cmd.rd_op)
      RD_ITEM: rd_en = 1'b1;
      RD_SCROLL: begin
        rd_en   = 1'b1;
        rd_addr = {sc_row + ROW_W'(1), sc_col};
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (cmd.load_out) begin
      rsp_valid <= 1'b1;
    end else if (rsp_ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      pos_row    <= cur_row;
      pos_col    <= cur_col;
      read_char  <= (item_cmd == CMD_READ) ? rd_data : 8'd0;
      stale_rows <= row_changed;
      scrolled   <= scroll_flag;
    end
  end

  always_comb begin
    st.item_cmd      = item_cmd;
    st.ch_cr         = (item_ch == CH_CR);
    st.ch_lf         = (item_ch == CH_LF);
    st.ch_ff         = (item_ch == CH_FF);
    st.ch_bs         = (item_ch == CH_BS);
    st.need_scroll   = need_scroll;
    st.rows_one      = (rows_eff == NROW_W'(1));
    st.scan_col_last = col_last;
    st.scan_row_last = ({1'b0, sc_row} == (rows_eff - NROW_W'(2)));
    st.sweep_last    = (sweep_addr == {ADDR_W{1'b1}});
    st.copy_pend     = copy_pend;
    st.out_free      = !rsp_valid || rsp_ready;
  end

endmodule

// File: hw/rtl/tcb_ctrl.sv
module tcb_ctrl
  import tcb_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        req_valid,
  output logic        req_ready,
  input  tcb_status_t st,
  output tcb_cmd_t    cmd
);

  localparam logic [2:0] S_CLEAR  = 3'd0;
  localparam logic [2:0] S_IDLE   = 3'd1;
  localparam logic [2:0] S_DECODE = 3'd2;
  localparam logic [2:0] S_SCROLL = 3'd3;
  localparam logic [2:0] S_DRAIN  = 3'd4;
  localparam logic [2:0] S_FILL   = 3'd5;
  localparam logic [2:0] S_WRITE  = 3'd6;
  localparam logic [2:0] S_DONE   = 3'd7;

  logic [2:0] state;
  logic [2:0] state_next;
  logic       boot;
  logic       boot_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
      boot  <= 1'b1;
    end else begin
      state <= state_next;
      boot  <= boot_next;
    end
  end

  always_comb begin
    cmd        = '0;
    state_next = state;
    boot_next  = boot;
    req_ready  = 1'b0;
    case (state)
      S_CLEAR: begin
        cmd.wr_op = WR_SWEEP;
        if (st.sweep_last) begin
          state_next = boot ? S_IDLE : S_DONE;
          boot_next  = 1'b0;
        end
      end
      S_IDLE: begin
        req_ready = 1'b1;
        if (req_valid) begin
          cmd.load_item = 1'b1;
          state_next    = S_DECODE;
        end
      end
      S_DECODE: begin
        state_next = S_DONE;
        case (st.item_cmd)
          CMD_PUT: begin
            if (st.ch_ff) begin
              cmd.cur_op     = CUR_HOME;
              cmd.mask_clear = 1'b1;
              state_next     = S_CLEAR;
            end else if (!st.ch_cr) begin
              cmd.cur_op = CUR_FIX;
              if (st.need_scroll) begin
                cmd.scroll_start = 1'b1;
                state_next       = st.rows_one ? S_FILL : S_SCROLL;
              end else if (!st.ch_lf && !st.ch_bs) begin
                state_next = S_WRITE;
              end
            end
          end
          CMD_READ:  cmd.rd_op = RD_ITEM;
          CMD_FRESH: cmd.mask_clear = 1'b1;
          default: ;
        endcase
      end
      S_SCROLL: begin
        cmd.rd_op = RD_SCROLL;
        if (st.scan_col_last && st.scan_row_last) begin
          state_next = S_DRAIN;
        end
      end
      S_DRAIN: state_next = S_FILL;
      S_FILL: begin
        cmd.wr_op = WR_FILL;
        if (st.scan_col_last) begin
          state_next = (st.ch_lf || st.ch_bs) ? S_DONE : S_WRITE;
        end
      end
      S_WRITE: begin
        cmd.wr_op  = WR_PUT;
        cmd.cur_op = CUR_ADV;
        state_next = S_DONE;
      end
      S_DONE: begin
        if (st.out_free) begin
          cmd.load_out = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule

// File: hw/rtl/text_console_char_buffer.sv
// Channel  Dir  Handshake     Payload
// req      in   valid/ready   command, char_code, read_row, read_col
// rsp      out  valid/ready   pos_row, pos_col, read_char, stale_rows, scrolled
// cfg      in   cfg_wr_en     cfg_index, cfg_data
//
// An item passes through accept, decode and result, and a printable byte also through
// a write step on the single write port of the character memory.
// A scroll copies the rows up and fills the bottom row, or only fills it with one row.
// A form feed sweeps spaces through the whole memory.
// After reset the same clearing pass runs before the first item is taken.
// The result waits in an output register, so a stalled rsp holds only the next result.
`include "assert_macros.svh"

module text_console_char_buffer
  import tcb_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_wr_en,
  input  logic              cfg_index,
  input  logic [NCOL_W-1:0] cfg_data,
  tcb_in_if.sink            req,
  tcb_out_if.source         rsp
);

  tcb_cmd_t    cmd;
  tcb_status_t st;

  tcb_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req.valid),
    .req_ready (req.ready),
    .st        (st),
    .cmd       (cmd)
  );

  tcb_datapath u_datapath (
    .clk        (clk),
    .rst        (rst),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .command    (req.command),
    .char_code  (req.char_code),
    .read_row   (req.read_row),
    .read_col   (req.read_col),
    .rsp_ready  (rsp.ready),
    .rsp_valid  (rsp.valid),
    .pos_row    (rsp.pos_row),
    .pos_col    (rsp.pos_col),
    .read_char  (rsp.read_char),
    .stale_rows (rsp.stale_rows),
    .scrolled   (rsp.scrolled),
    .cmd        (cmd),
    .st         (st)
  );

  `ASSERT_PROP(a_idle_no_copy, clk, rst, req.ready |-> !st.copy_pend)
  `ASSERT_NEVER(a_one_write_port, clk, rst, st.copy_pend && (cmd.wr_op != WR_NONE))
  `ASSERT_PROP(a_busy_after_accept, clk, rst, (req.valid && req.ready) |=> !req.ready)

endmodule
